// ===== rtl/vzd_pkg.sv =====
// Shared types and codes for the varint and zigzag decoder.
package vzd_pkg;

    // Input item kinds.
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Value kinds.
    localparam logic [1:0] VK_U32 = 2'd0;
    localparam logic [1:0] VK_U64 = 2'd1;
    localparam logic [1:0] VK_S64 = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;

    localparam int unsigned GROUP_BITS   = 7;
    localparam int unsigned CONT_BIT     = 7;
    localparam logic [7:0]  LAST32_LIMIT = 8'h0f;
    localparam logic [7:0]  LAST64_LIMIT = 8'h01;
    localparam logic [3:0]  LAST32_INDEX = 4'd4;
    localparam logic [3:0]  LAST64_INDEX = 4'd9;

    typedef enum logic [1:0] {
        OP_DATA,
        OP_START,
        OP_END
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] value_kind;
        logic [7:0] data_byte;
    } t_item;

endpackage

// ===== rtl/vzd_front.sv =====
// Front end: accepts input transactions, classifies them and feeds the queue.
module vzd_front
    import vzd_pkg::*;
(
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_data_byte,
    input  logic [1:0] i_value_kind,
    input  logic       i_queue_full,
    output logic       o_push,
    output t_item      o_item
);

    logic w_accept;
    logic w_known;

    assign o_stall  = i_queue_full;
    assign w_accept = i_valid && !i_queue_full;

    always_comb begin
        w_known           = 1'b1;
        o_item.op         = OP_DATA;
        o_item.data_byte  = i_data_byte;
        // An unused value kind code is handled as unsigned 64-bit.
        o_item.value_kind = (i_value_kind == VK_U32 || i_value_kind == VK_S64) ?
                            i_value_kind : VK_U64;
        case (i_kind)
            KIND_DATA:  o_item.op = OP_DATA;
            KIND_START: o_item.op = OP_START;
            KIND_END:   o_item.op = OP_END;
            default:    w_known = 1'b0;
        endcase
    end

    // Transactions of an unknown kind are taken and dropped here.
    assign o_push = w_accept && w_known;

endmodule

// ===== rtl/vzd_queue.sv =====
// Short queue that decouples the front end from the decode back end.
module vzd_queue
    import vzd_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_valid,
    output logic  o_full,
    output t_item o_item
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_item  = r_mem[r_rptr];
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        n_count = r_count + CNT_W'(i_push) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue occupancy beyond its depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("write into a full queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_count == $past(r_count) + CNT_W'($past(i_push)) - CNT_W'($past(w_pop)))
        else $error("queue occupancy does not follow writes and reads");

endmodule

// ===== rtl/vzd_back.sv =====
// Back end: assembles varints, undoes zigzag, tracks errors and holds the result register.
module vzd_back
    import vzd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_item_valid,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_decoded_value,
    output logic [1:0]  o_status,
    output logic [3:0]  o_byte_length
);

    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_count, n_count;
    logic [1:0]  r_kind, n_kind;
    logic        r_in_progress, n_in_progress;
    logic [1:0]  r_error, n_error;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_out_value, n_out_value;
    logic [1:0]  r_out_status, n_out_status;
    logic [3:0]  r_out_length, n_out_length;

    logic [63:0] w_base_acc;
    logic [3:0]  w_base_count;
    logic [1:0]  w_cur_kind;
    logic        w_wide;
    logic        w_over;
    logic [6:0]  w_shift;
    logic [63:0] w_group;
    logic [63:0] w_acc_new;
    logic [63:0] w_value;

    assign o_pop = i_item_valid && (!r_out_valid || !i_stall);

    // A varint's first byte starts from a clean accumulator and takes its value kind.
    assign w_base_acc   = r_in_progress ? r_acc   : '0;
    assign w_base_count = r_in_progress ? r_count : '0;
    assign w_cur_kind   = r_in_progress ? r_kind  : i_item.value_kind;
    assign w_wide       = (w_cur_kind != VK_U32);

    assign w_over = (!w_wide && w_base_count == LAST32_INDEX &&
                     i_item.data_byte > LAST32_LIMIT) ||
                    (w_wide && w_base_count == LAST64_INDEX &&
                     i_item.data_byte > LAST64_LIMIT);

    assign w_shift   = {3'b000, w_base_count} * 7'(GROUP_BITS);
    assign w_group   = {57'd0, i_item.data_byte[GROUP_BITS-1:0]} << w_shift[5:0];
    assign w_acc_new = w_base_acc | w_group;
    assign w_value   = (w_cur_kind == VK_S64) ?
                       ((w_acc_new >> 1) ^ {64{w_acc_new[0]}}) : w_acc_new;

    always_comb begin
        n_acc         = r_acc;
        n_count       = r_count;
        n_kind        = r_kind;
        n_in_progress = r_in_progress;
        n_error       = r_error;
        n_out_valid   = r_out_valid && i_stall;
        n_out_value   = r_out_value;
        n_out_status  = r_out_status;
        n_out_length  = r_out_length;

        if (o_pop) begin
            case (i_item.op)
                OP_START: begin
                    n_acc         = '0;
                    n_count       = '0;
                    n_kind        = VK_U32;
                    n_in_progress = 1'b0;
                    n_error       = ST_OK;
                end
                OP_END: begin
                    if (r_error == ST_OK && r_in_progress) begin
                        n_out_valid   = 1'b1;
                        n_out_value   = '0;
                        n_out_status  = ST_TRUNC;
                        n_out_length  = r_count;
                        n_acc         = '0;
                        n_count       = '0;
                        n_kind        = VK_U32;
                        n_in_progress = 1'b0;
                        n_error       = ST_TRUNC;
                    end
                end
                OP_DATA: begin
                    if (r_error == ST_OK) begin
                        if (w_over) begin
                            n_out_valid   = 1'b1;
                            n_out_value   = '0;
                            n_out_status  = ST_OVER;
                            n_out_length  = w_base_count + 4'd1;
                            n_acc         = '0;
                            n_count       = '0;
                            n_kind        = VK_U32;
                            n_in_progress = 1'b0;
                            n_error       = ST_OVER;
                        end else if (!i_item.data_byte[CONT_BIT]) begin
                            n_out_valid   = 1'b1;
                            n_out_value   = w_value;
                            n_out_status  = ST_OK;
                            n_out_length  = w_base_count + 4'd1;
                            n_acc         = '0;
                            n_count       = '0;
                            n_kind        = VK_U32;
                            n_in_progress = 1'b0;
                        end else begin
                            n_acc         = w_acc_new;
                            n_count       = w_base_count + 4'd1;
                            n_kind        = w_cur_kind;
                            n_in_progress = 1'b1;
                        end
                    end
                end
                default: begin
                    n_in_progress = r_in_progress;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc         <= '0;
            r_count       <= '0;
            r_kind        <= VK_U32;
            r_in_progress <= 1'b0;
            r_error       <= ST_OK;
            r_out_valid   <= 1'b0;
        end else begin
            r_acc         <= n_acc;
            r_count       <= n_count;
            r_kind        <= n_kind;
            r_in_progress <= n_in_progress;
            r_error       <= n_error;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_length <= n_out_length;
    end

    assign o_valid         = r_out_valid;
    assign o_decoded_value = r_out_value;
    assign o_status        = r_out_status;
    assign o_byte_length   = r_out_length;

    a_busy_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_progress |-> r_error == ST_OK)
        else $error("varint in progress while the error latch is set");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_progress |-> (r_kind == VK_U32) ? (r_count <= LAST32_INDEX)
                                             : (r_count <= LAST64_INDEX))
        else $error("partial varint longer than its kind allows");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status != ST_OK |-> r_out_value == '0)
        else $error("error result carries a non-zero value");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_item.op == OP_START |=> !r_in_progress && r_error == ST_OK)
        else $error("start transaction did not clear the decoder");

endmodule

// ===== rtl/varint_zigzag_decoder_core.sv =====
// Top level of the LEB128 varint decoder with zigzag undo.
// Throughput: one input transaction per cycle while the queue is not full; the queue
// fills only while i_stall holds a pending result. Each item passes through the queue,
// and a result is registered in the back end once its last byte is popped.
// o_stall rises only when the QUEUE_DEPTH-entry queue is full (output held stalled).
// Synchronous active-low reset empties the queue, clears the partial varint and the
// error latch, and drops any pending result.
module varint_zigzag_decoder_core
    import vzd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_data_byte,
    input  logic [1:0]  i_value_kind,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_decoded_value,
    output logic [1:0]  o_status,
    output logic [3:0]  o_byte_length
);

    logic  w_push;
    logic  w_full;
    logic  w_q_valid;
    logic  w_pop;
    t_item w_push_item;
    t_item w_head_item;

    vzd_front u_front (
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_data_byte  (i_data_byte),
        .i_value_kind (i_value_kind),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_item       (w_push_item)
    );

    vzd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_full),
        .o_item  (w_head_item)
    );

    vzd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (w_q_valid),
        .i_item          (w_head_item),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_decoded_value (o_decoded_value),
        .o_status        (o_status),
        .o_byte_length   (o_byte_length)
    );

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the varint decoder: directed and random byte streams against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import vzd_pkg::*;

    // Codes that the package leaves unnamed but the ports can carry.
    localparam logic [1:0] KIND_RESERVED = 2'd3;
    localparam logic [1:0] VK_RESERVED   = 2'd3;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
        logic [3:0]  length;
    } t_vz_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_kind = KIND_DATA;
    logic [7:0]  i_data_byte = 8'h00;
    logic [1:0]  i_value_kind = VK_U32;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_decoded_value;
    logic [1:0]  o_status;
    logic [3:0]  o_byte_length;

    // Predictor state.
    logic [63:0] acc_value = '0;
    logic [3:0]  acc_count = '0;
    logic [1:0]  acc_kind = VK_U32;
    logic        varint_open = 1'b0;
    logic [1:0]  err_latch = ST_OK;

    t_vz_result  pending_decodes[$];
    bit          idle_on = 1'b1;
    int          stall_left = 0;
    int          mismatch_count = 0;
    int          items_accepted = 0;
    int          results_checked = 0;
    int          status_count[4] = '{0, 0, 0, 0};

    varint_zigzag_decoder_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_data_byte     (i_data_byte),
        .i_value_kind    (i_value_kind),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_decoded_value (o_decoded_value),
        .o_status        (o_status),
        .o_byte_length   (o_byte_length)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic void drop_varint();
        acc_value = '0;
        acc_count = '0;
        acc_kind = VK_U32;
        varint_open = 1'b0;
    endfunction

    // Works out the result, if any, that one accepted transaction causes.
    function automatic void decode_item(input logic [1:0] kind, input logic [7:0] data,
                                        input logic [1:0] vk);
        t_vz_result res;
        logic [3:0] idx;
        logic       wide;
        res = '0;
        if (kind == KIND_START) begin
            drop_varint();
            err_latch = ST_OK;
            return;
        end
        if (kind == KIND_END) begin
            if (err_latch == ST_OK && varint_open) begin
                res.status = ST_TRUNC;
                res.length = acc_count;
                drop_varint();
                err_latch = ST_TRUNC;
                pending_decodes.push_back(res);
            end
            return;
        end
        if (kind != KIND_DATA || err_latch != ST_OK) return;
        if (!varint_open) begin
            acc_value = '0;
            acc_count = '0;
            acc_kind = (vk == VK_RESERVED) ? VK_U64 : vk;
            varint_open = 1'b1;
        end
        idx = acc_count;
        wide = (acc_kind != VK_U32);
        res.length = idx + 4'd1;
        if ((!wide && idx == LAST32_INDEX && data > LAST32_LIMIT) ||
            (wide && idx == LAST64_INDEX && data > LAST64_LIMIT)) begin
            res.status = ST_OVER;
            drop_varint();
            err_latch = ST_OVER;
            pending_decodes.push_back(res);
            return;
        end
        acc_value |= 64'(data[6:0]) << (GROUP_BITS * idx);
        acc_count = res.length;
        if (!data[CONT_BIT]) begin
            res.status = ST_OK;
            res.value = (acc_kind == VK_S64) ? ((acc_value >> 1) ^ {64{acc_value[0]}})
                                             : acc_value;
            drop_varint();
            pending_decodes.push_back(res);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_stall === 1'b0) begin
            items_accepted++;
            decode_item(i_kind, i_data_byte, i_value_kind);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_vz_result want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_decodes.size() == 0) begin
                report_mismatch($sformatf("result with none expected: value %h status %0d len %0d",
                                          o_decoded_value, o_status, o_byte_length));
            end else begin
                want = pending_decodes.pop_front();
                results_checked++;
                status_count[want.status]++;
                if (o_decoded_value !== want.value)
                    report_mismatch($sformatf("decoded_value %h, expected %h",
                                              o_decoded_value, want.value));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d", o_status, want.status));
                if (o_byte_length !== want.length)
                    report_mismatch($sformatf("byte_length %0d, expected %0d",
                                              o_byte_length, want.length));
            end
        end
    end

    // Output back-pressure in random bursts while idle_on is set.
    always @(posedge i_clk) begin
        if (!idle_on) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 12);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Presents one transaction and returns at the edge that accepts it, valid left high.
    task automatic drive_item(input logic [1:0] kind, input logic [7:0] data,
                              input logic [1:0] vk);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_data_byte <= data;
        i_value_kind <= vk;
        do @(posedge i_clk); while (o_stall !== 1'b0);
    endtask

    // Sends the 7-bit groups of raw as a varint of nbytes bytes.
    task automatic send_varint(input logic [1:0] vk, input logic [63:0] raw, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            drive_item(KIND_DATA, {(i != nbytes - 1), 7'(raw >> (GROUP_BITS * i))}, vk);
    endtask

    task automatic test_single_bytes();
        send_varint(VK_U32, 64'd0, 1);
        send_varint(VK_U64, 64'h7f, 1);
        send_varint(VK_S64, 64'd1, 1);
        send_varint(VK_S64, 64'd2, 1);
    endtask

    task automatic test_width_limits();
        send_varint(VK_U32, 64'hffff_ffff, 5);
        send_varint(VK_U64, '1, 10);
        send_varint(VK_S64, 64'h3fff, 2);
    endtask

    task automatic test_overflow_latch();
        repeat (4) drive_item(KIND_DATA, 8'hff, VK_U32);
        drive_item(KIND_DATA, 8'h10, VK_U32);
        // Latched: the data byte is dropped and the end of buffer does nothing.
        drive_item(KIND_DATA, 8'h05, VK_U64);
        drive_item(KIND_END, 8'h00, VK_U32);
        drive_item(KIND_START, 8'h00, VK_U32);
        repeat (9) drive_item(KIND_DATA, 8'h80, VK_U64);
        drive_item(KIND_DATA, 8'h02, VK_U64);
        drive_item(KIND_START, 8'hff, VK_S64);
    endtask

    task automatic test_truncation();
        drive_item(KIND_END, 8'h00, VK_U32);
        drive_item(KIND_DATA, 8'h80, VK_S64);
        drive_item(KIND_DATA, 8'hff, VK_U32);
        drive_item(KIND_END, 8'h00, VK_U32);
        drive_item(KIND_END, 8'h00, VK_U32);
        drive_item(KIND_DATA, 8'h01, VK_U32);
        drive_item(KIND_START, 8'h00, VK_U32);
    endtask

    task automatic test_ignored_items();
        // The value kind is taken from the first byte only; the reserved kind is ignored.
        drive_item(KIND_DATA, 8'h81, VK_U32);
        drive_item(KIND_RESERVED, 8'hff, VK_RESERVED);
        drive_item(KIND_DATA, 8'h01, VK_S64);
        drive_item(KIND_DATA, 8'hff, VK_RESERVED);
        drive_item(KIND_START, 8'h00, VK_U32);
        drive_item(KIND_DATA, 8'h05, VK_U32);
        send_varint(VK_RESERVED, 64'h8000_0000_0000_0000, 10);
    endtask

    task automatic test_random_stream(input int target);
        int counted, nbytes, last_idx, sel, n;
        logic [1:0] vk;
        logic [7:0] b, limit;
        bit make_over, make_trunc, latched;
        counted = 0;
        latched = 1'b0;
        while (counted < target) begin
            idle_on <= !((counted >= 300 && counted < 400) || counted >= target - 250);
            sel = $urandom_range(0, 99);
            if (latched) begin
                if (sel < 60) begin
                    drive_item(KIND_START, 8'($urandom), 2'($urandom));
                    latched = 1'b0;
                    counted++;
                end else if (sel < 85) begin
                    drive_item(KIND_DATA, 8'($urandom), 2'($urandom));
                end else begin
                    drive_item(KIND_END, 8'($urandom), 2'($urandom));
                end
            end else if (sel < 82) begin
                vk = ($urandom_range(0, 9) == 0) ? VK_RESERVED : 2'($urandom_range(0, 2));
                last_idx = (vk == VK_U32) ? LAST32_INDEX : LAST64_INDEX;
                limit = (vk == VK_U32) ? LAST32_LIMIT : LAST64_LIMIT;
                nbytes = ($urandom_range(0, 5) == 0) ? last_idx + 1 : $urandom_range(1, 3);
                make_over = (nbytes == last_idx + 1) && ($urandom_range(0, 3) == 0);
                make_trunc = !make_over && ($urandom_range(0, 9) == 0);
                if (make_trunc && nbytes > last_idx) nbytes = last_idx;
                for (int i = 0; i < nbytes; i++) begin
                    if ($urandom_range(0, 19) == 0)
                        drive_item(KIND_RESERVED, 8'($urandom), 2'($urandom));
                    if (i == last_idx)
                        b = make_over ? 8'($urandom_range(int'(limit) + 1, 255))
                                      : 8'($urandom_range(0, int'(limit)));
                    else
                        b = {(make_trunc || i < nbytes - 1), 7'($urandom)};
                    drive_item(KIND_DATA, b, (i == 0) ? vk : 2'($urandom));
                end
                counted += nbytes;
                if (make_trunc) begin
                    drive_item(KIND_END, 8'($urandom), 2'($urandom));
                    counted++;
                end
                latched = make_over || make_trunc;
            end else if (sel < 90) begin
                // A partial varint abandoned by a new buffer.
                n = $urandom_range(1, 3);
                repeat (n) drive_item(KIND_DATA, {1'b1, 7'($urandom)}, 2'($urandom));
                drive_item(KIND_START, 8'($urandom), 2'($urandom));
                counted += n + 1;
            end else if (sel < 95) begin
                drive_item(KIND_END, 8'($urandom), 2'($urandom));
            end else begin
                drive_item(KIND_RESERVED, 8'($urandom), 2'($urandom));
            end
        end
    endtask

    task automatic finish_stimulus();
        i_valid <= 1'b0;
        idle_on <= 1'b0;
        while (pending_decodes.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_single_bytes();
        test_width_limits();
        test_overflow_latch();
        test_truncation();
        test_ignored_items();
        test_random_stream(800);
        finish_stimulus();
        $display("Run covered %0d accepted transactions and %0d checked results", items_accepted,
                 results_checked);
        $display("Results by status: %0d ok, %0d truncated, %0d overflow", status_count[ST_OK],
                 status_count[ST_TRUNC], status_count[ST_OVER]);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Timeout with %0d results outstanding", pending_decodes.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/vzd_pkg.sv
rtl/vzd_front.sv
rtl/vzd_queue.sv
rtl/vzd_back.sv
rtl/varint_zigzag_decoder_core.sv
dv/tb_top.sv
